// ===== src/tsai_pkg.sv =====
// ============================================================================
// tsai_pkg
// Shared types and constants of the 2xSaI pixel upscaler.
// ============================================================================
package tsai_pkg;

    // one 16-bit source or output pixel
    typedef logic [15:0] pixel_t;

    // configuration register index
    localparam int unsigned CfgIdxW = 2;
    typedef logic [CfgIdxW-1:0] cfg_idx_t;

    localparam cfg_idx_t CfgHalfColor    = 2'd0;
    localparam cfg_idx_t CfgHalfLow      = 2'd1;
    localparam cfg_idx_t CfgQuarterColor = 2'd2;
    localparam cfg_idx_t CfgQuarterLow   = 2'd3;

    // mask reset values (five-six-five pixel layout)
    localparam pixel_t HalfColorReset    = 16'hF7DE;
    localparam pixel_t HalfLowReset      = 16'h0821;
    localparam pixel_t QuarterColorReset = 16'hE79C;
    localparam pixel_t QuarterLowReset   = 16'h1863;

    // columns held before a block can be produced
    localparam logic [1:0] FillFull = 2'd3;

    // channel masks for the blends
    typedef struct packed {
        pixel_t half_color;
        pixel_t half_low;
        pixel_t quarter_color;
        pixel_t quarter_low;
    } mask_t;

    // 4x4 neighbourhood around the centre pixel a
    //   i e f j
    //   g a b k
    //   h c d l
    //   m n o
    typedef struct packed {
        pixel_t i;
        pixel_t e;
        pixel_t f;
        pixel_t j;
        pixel_t g;
        pixel_t a;
        pixel_t b;
        pixel_t k;
        pixel_t h;
        pixel_t c;
        pixel_t d;
        pixel_t l;
        pixel_t m;
        pixel_t n;
        pixel_t o;
    } window_t;

    // one 2x2 output block
    typedef struct packed {
        pixel_t top_left;
        pixel_t top_right;
        pixel_t bottom_left;
        pixel_t bottom_right;
    } block_t;

endpackage

// ===== src/tsai_if.sv =====
// ============================================================================
// tsai interfaces
// Valid/ready channels of the upscaler: source columns, output blocks and
// the configuration write channel.
// ============================================================================

// source column channel
interface tsai_col_if;
    logic             valid;
    logic             ready;
    tsai_pkg::pixel_t pixel_above;
    tsai_pkg::pixel_t pixel_current;
    tsai_pkg::pixel_t pixel_below;
    tsai_pkg::pixel_t pixel_below_two;
    logic             line_start;

    modport src (
        output valid, pixel_above, pixel_current, pixel_below, pixel_below_two,
               line_start,
        input  ready
    );
    modport snk (
        input  valid, pixel_above, pixel_current, pixel_below, pixel_below_two,
               line_start,
        output ready
    );
endinterface

// output block channel
interface tsai_blk_if;
    logic             valid;
    logic             ready;
    tsai_pkg::pixel_t out_top_left;
    tsai_pkg::pixel_t out_top_right;
    tsai_pkg::pixel_t out_bottom_left;
    tsai_pkg::pixel_t out_bottom_right;

    modport src (
        output valid, out_top_left, out_top_right, out_bottom_left,
               out_bottom_right,
        input  ready
    );
    modport snk (
        input  valid, out_top_left, out_top_right, out_bottom_left,
               out_bottom_right,
        output ready
    );
endinterface

// configuration write channel
interface tsai_cfg_if;
    logic               valid;
    logic               ready;
    tsai_pkg::cfg_idx_t index;
    tsai_pkg::pixel_t   data;

    modport src (
        output valid, index, data,
        input  ready
    );
    modport snk (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== src/tsai_kernel.sv =====
// ============================================================================
// tsai_kernel
// 2xSaI decision logic: turns one 4x4 neighbourhood into a 2x2 output block
// using the edge tests, the neighbour vote and the masked blends.
// ============================================================================
module tsai_kernel (
    input  tsai_pkg::window_t win,
    input  tsai_pkg::mask_t   masks,
    output tsai_pkg::block_t  blk
);

    // two-pixel blend with rounding bit
    function automatic tsai_pkg::pixel_t blend2(
        input tsai_pkg::pixel_t p,
        input tsai_pkg::pixel_t q,
        input tsai_pkg::mask_t  mk
    );
        blend2 = ((p & mk.half_color) >> 1) + ((q & mk.half_color) >> 1)
            + (p & q & mk.half_low);
    endfunction

    // four-pixel blend, low-bit remainders summed separately
    function automatic tsai_pkg::pixel_t blend4(
        input tsai_pkg::pixel_t p,
        input tsai_pkg::pixel_t q,
        input tsai_pkg::pixel_t r,
        input tsai_pkg::pixel_t s,
        input tsai_pkg::mask_t  mk
    );
        tsai_pkg::pixel_t hi;
        logic [17:0]      lo_sum;
        tsai_pkg::pixel_t lo;
        hi = ((p & mk.quarter_color) >> 2) + ((q & mk.quarter_color) >> 2)
            + ((r & mk.quarter_color) >> 2) + ((s & mk.quarter_color) >> 2);
        lo_sum = {2'b00, p & mk.quarter_low} + {2'b00, q & mk.quarter_low}
            + {2'b00, r & mk.quarter_low} + {2'b00, s & mk.quarter_low};
        lo = lo_sum[17:2] & mk.quarter_low;
        blend4 = hi + lo;
    endfunction

    tsai_pkg::pixel_t a;
    tsai_pkg::pixel_t b;
    tsai_pkg::pixel_t c;
    tsai_pkg::pixel_t d;
    tsai_pkg::pixel_t half_ab;
    tsai_pkg::pixel_t half_ac;
    tsai_pkg::pixel_t quarter;
    logic [3:0]       vote_a;
    logic [3:0]       vote_b;
    logic [2:0]       cnt_a;
    logic [2:0]       cnt_b;

    assign a = win.a;
    assign b = win.b;
    assign c = win.c;
    assign d = win.d;

    // shared blends
    assign half_ab = blend2(a, b, masks);
    assign half_ac = blend2(a, c, masks);
    assign quarter = blend4(a, b, c, d, masks);

    // neighbour vote: count of neighbour pairs differing from a and from b
    assign vote_a = {(a != win.e) || (a != win.g), (a != win.f) || (a != win.k),
                     (a != win.h) || (a != win.n), (a != win.l) || (a != win.o)};
    assign vote_b = {(b != win.e) || (b != win.g), (b != win.f) || (b != win.k),
                     (b != win.h) || (b != win.n), (b != win.l) || (b != win.o)};
    assign cnt_a = 3'(vote_a[0]) + 3'(vote_a[1]) + 3'(vote_a[2]) + 3'(vote_a[3]);
    assign cnt_b = 3'(vote_b[0]) + 3'(vote_b[1]) + 3'(vote_b[2]) + 3'(vote_b[3]);

    // edge rules
    always_comb
    begin
        blk.top_left     = a;
        blk.top_right    = half_ab;
        blk.bottom_left  = half_ac;
        blk.bottom_right = quarter;
        if ((a == d) && (b != c))
        begin
            // diagonal edge through a and d
            if (((a == win.e) && (b == win.l)) ||
                ((a == c) && (a == win.f) && (b != win.e) && (b == win.j)))
            begin
                blk.top_right = a;
            end
            if (((a == win.g) && (c == win.o)) ||
                ((a == b) && (a == win.h) && (win.g != c) && (c == win.m)))
            begin
                blk.bottom_left = a;
            end
            blk.bottom_right = a;
        end
        else if ((b == c) && (a != d))
        begin
            // diagonal edge through b and c
            if (((b == win.f) && (a == win.h)) ||
                ((b == win.e) && (b == d) && (a != win.f) && (a == win.i)))
            begin
                blk.top_right = b;
            end
            if (((c == win.h) && (a == win.f)) ||
                ((c == win.g) && (c == d) && (a != win.h) && (a == win.i)))
            begin
                blk.bottom_left = c;
            end
            blk.bottom_right = b;
        end
        else if ((a == d) && (b == c))
        begin
            if (a == b)
            begin
                // flat area
                blk.top_right    = a;
                blk.bottom_left  = a;
                blk.bottom_right = a;
            end
            else if (cnt_a > cnt_b)
            begin
                blk.bottom_right = a;
            end
            else if (cnt_a < cnt_b)
            begin
                blk.bottom_right = b;
            end
        end
        else
        begin
            // no diagonal edge
            if ((a == c) && (a == win.f) && (b != win.e) && (b == win.j))
            begin
                blk.top_right = a;
            end
            else if ((b == win.e) && (b == d) && (a != win.f) && (a == win.i))
            begin
                blk.top_right = b;
            end
            if ((a == b) && (a == win.h) && (win.g != c) && (c == win.m))
            begin
                blk.bottom_left = a;
            end
            else if ((c == win.g) && (c == d) && (a != win.h) && (a == win.i))
            begin
                blk.bottom_left = c;
            end
        end
    end

endmodule

// ===== src/two_x_sai_upscaler.sv =====
// ============================================================================
// two_x_sai_upscaler
// 2xSaI pixel-art upscaler: one source column in, one 2x2 output block out.
// ============================================================================
// Usage:
//   pixels : source columns, four rows each; line_start marks column -1 of a
//            line. Send columns -1 through width+1 of every line.
//   result : one 2x2 block per column once three columns are held, i.e. for
//            every column from the fourth word after a line start onwards.
//   cfg    : mask writes, index 0..3; always ready, write only while idle.
// Timing:
//   one column word is accepted per clock unless the pipeline is stalled. A
//   block reaches result after its completing column word passes the window
//   register, then the decision logic into the output register.
// Reset:
//   pipeline empties, fill count clears, masks return to their defaults.
//   held window columns are not cleared; the fill count guards them.
// Stall:
//   while result is held, the pipeline stops and pixels.ready drops as soon
//   as both pipeline registers are full; no word is lost or repeated.
// ============================================================================
module two_x_sai_upscaler (
    input  logic       clk,
    input  logic       rst_n,
    tsai_col_if.snk    pixels,
    tsai_blk_if.src    result,
    tsai_cfg_if.snk    cfg
);

    tsai_pkg::mask_t   mask_reg;
    tsai_pkg::pixel_t  col_reg [3][4];
    logic [1:0]        fill_reg;
    logic [1:0]        fill_next;
    logic              s1_valid_reg;
    tsai_pkg::window_t s1_win_reg;
    tsai_pkg::window_t win_next;
    logic              out_valid_reg;
    tsai_pkg::block_t  out_blk_reg;
    tsai_pkg::block_t  blk_next;
    logic              out_adv;
    logic              in_accept;
    logic              win_full;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg.half_color    <= tsai_pkg::HalfColorReset;
            mask_reg.half_low      <= tsai_pkg::HalfLowReset;
            mask_reg.quarter_color <= tsai_pkg::QuarterColorReset;
            mask_reg.quarter_low   <= tsai_pkg::QuarterLowReset;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                tsai_pkg::CfgHalfColor:    mask_reg.half_color    <= cfg.data;
                tsai_pkg::CfgHalfLow:      mask_reg.half_low      <= cfg.data;
                tsai_pkg::CfgQuarterColor: mask_reg.quarter_color <= cfg.data;
                tsai_pkg::CfgQuarterLow:   mask_reg.quarter_low   <= cfg.data;
                default:                   mask_reg               <= mask_reg;
            endcase
        end
    end

    // pipeline handshake
    assign out_adv      = !out_valid_reg || result.ready;
    assign pixels.ready = !s1_valid_reg || out_adv;
    assign in_accept    = pixels.valid && pixels.ready;

    // fill tracking
    assign win_full = !pixels.line_start && (fill_reg == tsai_pkg::FillFull);

    always_comb
    begin
        fill_next = fill_reg;
        if (in_accept)
        begin
            if (pixels.line_start)
            begin
                fill_next = 2'd1;
            end
            else if (fill_reg != tsai_pkg::FillFull)
            begin
                fill_next = fill_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // neighbourhood from the held columns and the incoming one
    always_comb
    begin
        win_next.i = col_reg[0][0];
        win_next.e = col_reg[1][0];
        win_next.f = col_reg[2][0];
        win_next.j = pixels.pixel_above;
        win_next.g = col_reg[0][1];
        win_next.a = col_reg[1][1];
        win_next.b = col_reg[2][1];
        win_next.k = pixels.pixel_current;
        win_next.h = col_reg[0][2];
        win_next.c = col_reg[1][2];
        win_next.d = col_reg[2][2];
        win_next.l = pixels.pixel_below;
        win_next.m = col_reg[0][3];
        win_next.n = col_reg[1][3];
        win_next.o = col_reg[2][3];
    end

    // sliding column store
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            col_reg[0]    <= col_reg[1];
            col_reg[1]    <= col_reg[2];
            col_reg[2][0] <= pixels.pixel_above;
            col_reg[2][1] <= pixels.pixel_current;
            col_reg[2][2] <= pixels.pixel_below;
            col_reg[2][3] <= pixels.pixel_below_two;
        end
    end

    // window register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixels.ready)
        begin
            s1_valid_reg <= in_accept && win_full;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && win_full)
        begin
            s1_win_reg <= win_next;
        end
    end

    // decision logic
    tsai_kernel u_kernel (
        .win   (s1_win_reg),
        .masks (mask_reg),
        .blk   (blk_next)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            out_blk_reg <= blk_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.out_top_left     = out_blk_reg.top_left;
    assign result.out_top_right    = out_blk_reg.top_right;
    assign result.out_bottom_left  = out_blk_reg.bottom_left;
    assign result.out_bottom_right = out_blk_reg.bottom_right;

`ifndef NO_ASSERTIONS
    // a word that does not complete a window never enters the pipeline
    a_no_block_before_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (pixels.line_start || (fill_reg != tsai_pkg::FillFull)))
        |=> !s1_valid_reg)
        else $error("window stage loaded without a full window");

    // both stages full and output stalled: no further column is taken
    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready && s1_valid_reg) |-> !pixels.ready)
        else $error("column accepted while pipeline is full");

    // a new block only follows a loaded window stage
    a_block_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_adv && !s1_valid_reg) |=> !out_valid_reg)
        else $error("output block without a window behind it");

    // top-left output is the centre pixel of the window it came from
    a_centre_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (out_adv && s1_valid_reg) |=> (out_blk_reg.top_left == $past(s1_win_reg.a)))
        else $error("top-left pixel differs from window centre");
`endif

endmodule
